/* rtl/c2s_pkg.sv */
package c2s_pkg;

    localparam int COL_W = 10;
    localparam int ROW_W = 8;
    localparam int CTR_W = 10;

    typedef logic signed [CTR_W-1:0] t_ctr;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [COL_W-1:0] span_end;
        logic [ROW_W-1:0] prev_top;
        logic [ROW_W-1:0] prev_bottom;
        logic [ROW_W-1:0] cur_top;
        logic [ROW_W-1:0] cur_bottom;
    } t_cmd;

endpackage

/* rtl/c2s_if.sv */
interface c2s_col_if;
    import c2s_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] prev_top;
    logic [ROW_W-1:0] prev_bottom;
    logic [ROW_W-1:0] cur_top;
    logic [ROW_W-1:0] cur_bottom;

    modport source (output valid, column, prev_top, prev_bottom, cur_top, cur_bottom,
                    input ready);
    modport sink (input valid, column, prev_top, prev_bottom, cur_top, cur_bottom,
                  output ready);
endinterface

interface c2s_span_if;
    import c2s_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] span_row;
    logic [COL_W-1:0] span_start;
    logic [COL_W-1:0] span_end;
    logic             span_last;

    modport source (output valid, span_row, span_start, span_end, span_last,
                    input ready);
    modport sink (input valid, span_row, span_start, span_end, span_last,
                  output ready);
endinterface

/* rtl/column_to_span_converter_unit.sv */
// Column to span converter.
// Input channel i_col takes one request per screen column: the column index and
// the covered row interval of the previous and of the current column (top
// greater than bottom marks an empty column). Output channel o_span returns one
// request per closed row: row, start column, end column (column minus one) and
// a last flag on the final span of that column. A column with no closed row
// returns nothing.
// A request passes an input register and a two-entry queue, then a sequencer
// that walks the changed rows one at a time against a start-column memory with
// one read and one write port. For each column the sequencer first reads the
// start column of each closed row from memory before emitting its span, then
// writes the column as the start of each newly opened row.
// Reset clears all control state and marks every start entry as zero at once.
// When the receiver stalls, the output register holds its span, the sequencer
// waits, and the queue and input register keep taking requests until full.
module column_to_span_converter_unit #(
    parameter int ROWS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c2s_col_if.sink    i_col,
    c2s_span_if.source o_span
);
    import c2s_pkg::*;

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    c2s_front #(.ROWS(ROWS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_col       (i_col),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    c2s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    c2s_back #(.ROWS(ROWS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_span      (o_span)
    );

endmodule

/* rtl/c2s_front.sv */
module c2s_front #(
    parameter int ROWS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    c2s_col_if.sink          i_col,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output c2s_pkg::t_cmd    o_cmd
);
    import c2s_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign i_col.ready = !r_valid || i_cmd_ready;
    assign accept      = i_col.valid && i_col.ready;

    // clip both bottoms to the last stored row
    always_comb begin
        n_cmd.column      = i_col.column;
        n_cmd.span_end    = i_col.column - COL_W'(1);
        n_cmd.prev_top    = i_col.prev_top;
        n_cmd.prev_bottom = (i_col.prev_bottom > LAST_ROW) ? LAST_ROW : i_col.prev_bottom;
        n_cmd.cur_top     = i_col.cur_top;
        n_cmd.cur_bottom  = (i_col.cur_bottom > LAST_ROW) ? LAST_ROW : i_col.cur_bottom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

/* rtl/c2s_queue.sv */
module c2s_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  c2s_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output c2s_pkg::t_cmd o_cmd
);
    import c2s_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

/* rtl/c2s_back.sv */
module c2s_back #(
    parameter int ROWS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  c2s_pkg::t_cmd i_cmd,
    c2s_span_if.source    o_span
);
    import c2s_pkg::*;

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CT,
        ST_CB,
        ST_OUT,
        ST_OT,
        ST_OB
    } t_state;

    t_state           r_state;
    t_ctr             r_t1;
    t_ctr             r_b1;
    t_ctr             r_t2;
    t_ctr             r_b2;
    logic [COL_W-1:0] r_x;
    logic [COL_W-1:0] r_xm1;
    logic             r_top;
    logic [ROW_W-1:0] r_row;
    logic             r_more;
    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_start;
    logic [COL_W-1:0] r_out_end;
    logic             r_out_last;

    logic [COL_W-1:0] r_mem [ROWS];
    logic [COL_W-1:0] r_rdata;
    logic             r_rvld;
    logic [ROWS-1:0]  r_vbits;

    t_ctr             t1n;
    t_ctr             b1n;
    logic             ct_go;
    logic             cb_go;
    logic             ot_go;
    logic             ob_go;
    logic             ct_more;
    logic             cb_more;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             out_free;
    logic             out_load;

    assign t1n     = r_t1 + t_ctr'(1);
    assign b1n     = r_b1 - t_ctr'(1);
    assign ct_go   = (r_t1 < r_t2) && (r_t1 <= r_b1);
    assign cb_go   = (r_b1 > r_b2) && (r_b1 >= r_t1);
    assign ot_go   = (r_t2 < r_t1) && (r_t2 <= r_b2);
    assign ob_go   = (r_b2 > r_b1) && (r_b2 >= r_t2);
    assign ct_more = ((t1n < r_t2) && (t1n <= r_b1)) || ((r_b1 > r_b2) && (r_b1 >= t1n));
    assign cb_more = (b1n > r_b2) && (b1n >= r_t1);

    assign rd_en    = ((r_state == ST_CT) && ct_go) || ((r_state == ST_CB) && cb_go);
    assign rd_addr  = (r_state == ST_CT) ? r_t1[AW-1:0] : r_b1[AW-1:0];
    assign wr_en    = ((r_state == ST_OT) && ot_go) || ((r_state == ST_OB) && ob_go);
    assign wr_addr  = (r_state == ST_OT) ? r_t2[AW-1:0] : r_b2[AW-1:0];
    assign out_free = !r_out_valid || o_span.ready;
    assign out_load = (r_state == ST_OUT) && out_free;

    assign o_cmd_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_x;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vbits[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rvld <= r_vbits[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_span.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_t1    <= $signed({2'b00, i_cmd.prev_top});
                        r_b1    <= $signed({2'b00, i_cmd.prev_bottom});
                        r_t2    <= $signed({2'b00, i_cmd.cur_top});
                        r_b2    <= $signed({2'b00, i_cmd.cur_bottom});
                        r_x     <= i_cmd.column;
                        r_xm1   <= i_cmd.span_end;
                        r_state <= ST_CT;
                    end
                end
                ST_CT: begin
                    if (ct_go) begin
                        r_row   <= r_t1[ROW_W-1:0];
                        r_more  <= ct_more;
                        r_top   <= 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_CB;
                    end
                end
                ST_CB: begin
                    if (cb_go) begin
                        r_row   <= r_b1[ROW_W-1:0];
                        r_more  <= cb_more;
                        r_top   <= 1'b0;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_OT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_row   <= r_row;
                        r_out_start <= r_rvld ? r_rdata : '0;
                        r_out_end   <= r_xm1;
                        r_out_last  <= !r_more;
                        if (r_top) begin
                            r_t1    <= t1n;
                            r_state <= ST_CT;
                        end else begin
                            r_b1    <= b1n;
                            r_state <= ST_CB;
                        end
                    end
                end
                ST_OT: begin
                    if (ot_go) begin
                        r_t2 <= r_t2 + t_ctr'(1);
                    end else begin
                        r_state <= ST_OB;
                    end
                end
                ST_OB: begin
                    if (ob_go) begin
                        r_b2 <= r_b2 - t_ctr'(1);
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_span.valid      = r_out_valid;
    assign o_span.span_row   = r_out_row;
    assign o_span.span_start = r_out_start;
    assign o_span.span_end   = r_out_end;
    assign o_span.span_last  = r_out_last;

endmodule

/* rtl/c2s_checker.sv */
module c2s_checker #(
    parameter int ROWS = 64
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_span_valid,
    input logic                     i_span_ready,
    input logic [c2s_pkg::ROW_W-1:0] i_span_row,
    input logic [c2s_pkg::COL_W-1:0] i_span_start,
    input logic [c2s_pkg::COL_W-1:0] i_span_end,
    input logic                     i_span_last
);
    import c2s_pkg::*;

    logic             r_in_group;
    logic [COL_W-1:0] r_prev_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_group <= 1'b0;
        end else if (i_span_valid && i_span_ready) begin
            r_in_group <= !i_span_last;
            r_prev_end <= i_span_end;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_span_valid)
        else $error("span valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_span_valid && !i_span_ready |=> i_span_valid && $stable(i_span_row)
            && $stable(i_span_start) && $stable(i_span_end) && $stable(i_span_last))
        else $error("stalled span changed");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_span_valid |-> i_span_row <= ROW_W'(ROWS - 1))
        else $error("span row beyond store");

    a_group_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_span_valid && r_in_group |-> i_span_end == r_prev_end)
        else $error("span end changed within one column");

endmodule

bind column_to_span_converter_unit c2s_checker #(.ROWS(ROWS)) u_c2s_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_span_valid (o_span.valid),
    .i_span_ready (o_span.ready),
    .i_span_row   (o_span.span_row),
    .i_span_start (o_span.span_start),
    .i_span_end   (o_span.span_end),
    .i_span_last  (o_span.span_last)
);
